@@ rtl/whole_word_phrase_match_top_assert.svh @@
// Assertion macros for the top-level RTL.
`ifndef WHOLE_WORD_PHRASE_MATCH_TOP_ASSERT_SVH
`define WHOLE_WORD_PHRASE_MATCH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WWPM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("whole word phrase match: assertion failed");
`define WWPM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("whole word phrase match: assertion failed");
`else
`define WWPM_ASSERT_IMP(lbl, ante, cons)
`define WWPM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/wwpm_pkg.sv @@
package wwpm_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int PHRASE_BYTES = 32;
	localparam int PHRASE_IDX_W = 5;
	localparam int LEN_W = 6;
	localparam int LINE_W = 32;
	localparam int COL_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [LINE_W-1:0] LINE_MAX = '1;
	localparam logic [COL_W-1:0] COL_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 3'd4;

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_END = 1'b1;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	typedef struct packed {
		logic kind;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0] col;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t first;
		result_t second;
	} scan_out_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
			(c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
	endfunction

endpackage

@@ rtl/whole_word_phrase_match_top.sv @@
// Whole-word phrase search over a byte stream.
// Input channel (in_valid/in_ready) carries one text byte per transfer, or an
// end-of-input marker when end_of_input is set. Output channel
// (out_valid/out_ready) carries one result per transfer: a phrase match with
// its line (from 1) and start column (from 0), or the end marker.
// A byte yields at most one result; end of input yields an optional pending
// match followed by the end marker. last_result flags the final result of
// an input transfer.
// The phrase and its length are written through cfg_we/cfg_index/cfg_data
// while the stream is idle.
// The input byte and end flag are registered; the scan results then enter the
// result queue, whose count register drives out_valid. One byte is taken every
// cycle while the queue has room; the loop through the window and the line
// and column counters sets that rate. While out_ready stays high the input
// never stalls: the two-entry result queue takes both results of an end
// marker in the same cycle in which it sends one out.
// Reset sets the line counter to one and clears the column counter, the window,
// the queue and the phrase registers (length one). When the receiver stalls, the
// result queue fills and in_ready falls; nothing is dropped.
`include "whole_word_phrase_match_top_assert.svh"

module whole_word_phrase_match_top #(
	parameter int MAX_PATTERN = wwpm_pkg::MAX_PATTERN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [wwpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [wwpm_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] char_byte,
	input logic end_of_input,
	output logic out_valid,
	input logic out_ready,
	output logic result_kind,
	output logic [wwpm_pkg::LINE_W-1:0] line_number,
	output logic [wwpm_pkg::COL_W-1:0] column,
	output logic last_result
);

	logic in_valid_s1;
	logic [7:0] char_s1;
	logic eoi_s1;
	logic adv;
	logic [1:0] room;
	wwpm_pkg::scan_out_t scan_res;
	wwpm_pkg::result_t head;

	assign adv = in_valid_s1 && (scan_res.count <= room);
	assign in_ready = !in_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			in_valid_s1 <= 1'b1;
		end else if (adv) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			eoi_s1 <= end_of_input;
		end
	end

	wwpm_scan #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_byte_valid(in_valid_s1),
		.item_byte(char_s1),
		.item_eoi(eoi_s1),
		.adv(adv),
		.res(scan_res)
	);

	wwpm_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(adv),
		.res(scan_res),
		.room(room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head)
	);

	assign result_kind = head.kind;
	assign line_number = head.line;
	assign column = head.col;
	assign last_result = head.last;

	`WWPM_ASSERT_IMP(a_end_marker_last, out_valid && result_kind == wwpm_pkg::KIND_END, last_result)
	`WWPM_ASSERT_NXT(a_eoi_captured, in_valid && in_ready && end_of_input, in_valid_s1 && eoi_s1)
	`WWPM_ASSERT_NXT(a_eoi_gives_result, adv && eoi_s1, out_valid)
	`WWPM_ASSERT_IMP(a_byte_one_result, adv && !eoi_s1, scan_res.count <= 2'd1)

endmodule

@@ rtl/wwpm_scan.sv @@
module wwpm_scan #(
	parameter int MAX_PATTERN = wwpm_pkg::MAX_PATTERN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [wwpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [wwpm_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic item_byte_valid,
	input logic [7:0] item_byte,
	input logic item_eoi,
	input logic adv,
	output wwpm_pkg::scan_out_t res
);

	localparam int DEPTH = MAX_PATTERN + 1;
	localparam int FILL_W = $clog2(MAX_PATTERN + 2);
	localparam int CMP_W = wwpm_pkg::LEN_W + 1;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

	logic [3:0][63:0] pat_q;
	logic [wwpm_pkg::LEN_W-1:0] len_q;
	logic [wwpm_pkg::PHRASE_BYTES-1:0][7:0] phrase;
	logic [DEPTH-1:0][7:0] win_q;
	logic [FILL_W-1:0] fill_q;
	logic [wwpm_pkg::LINE_W-1:0] line_q;
	logic [wwpm_pkg::COL_W-1:0] col_q;

	logic [wwpm_pkg::LEN_W-1:0] used_len;
	logic [CMP_W-1:0] fill_ext;
	logic [CMP_W-1:0] len_ext;
	logic bytes_eq;
	logic left_bad;
	logic pending;
	logic [wwpm_pkg::COL_W-1:0] match_col;
	wwpm_pkg::result_t match_res;
	wwpm_pkg::result_t end_res;

	assign phrase = pat_q;
	assign used_len = (len_q > wwpm_pkg::LEN_W'(MAX_PATTERN)) ?
		wwpm_pkg::LEN_W'(MAX_PATTERN) : len_q;
	assign fill_ext = {{(CMP_W-FILL_W){1'b0}}, fill_q};
	assign len_ext = {1'b0, used_len};

	always_comb begin
		bytes_eq = 1'b1;
		left_bad = 1'b0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (wwpm_pkg::LEN_W'(j) < used_len) begin
				if (win_q[j] != phrase[wwpm_pkg::PHRASE_IDX_W'(used_len -
						wwpm_pkg::LEN_W'(j) - wwpm_pkg::LEN_W'(1))]) begin
					bytes_eq = 1'b0;
				end
			end
		end
		for (int j = 1; j < DEPTH; j++) begin
			if (wwpm_pkg::LEN_W'(j) == used_len && fill_ext > CMP_W'(j) &&
					wwpm_pkg::is_letter(win_q[j])) begin
				left_bad = 1'b1;
			end
		end
	end

	assign pending = (used_len != '0) && (fill_ext >= len_ext) && bytes_eq && !left_bad;
	assign match_col = (col_q == wwpm_pkg::COL_MAX) ? wwpm_pkg::COL_MAX :
		col_q - wwpm_pkg::COL_W'(used_len);

	always_comb begin
		match_res.kind = wwpm_pkg::KIND_MATCH;
		match_res.line = line_q;
		match_res.col = match_col;
		match_res.last = !item_eoi;
		end_res.kind = wwpm_pkg::KIND_END;
		end_res.line = line_q;
		end_res.col = col_q;
		end_res.last = 1'b1;
		res.first = match_res;
		res.second = end_res;
		res.count = 2'd0;
		if (item_byte_valid) begin
			if (item_eoi) begin
				if (pending) begin
					res.count = 2'd2;
				end else begin
					res.first = end_res;
					res.count = 2'd1;
				end
			end else if (pending && !wwpm_pkg::is_letter(item_byte)) begin
				res.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= wwpm_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				wwpm_pkg::REG_PATTERN_0: pat_q[0] <= cfg_data;
				wwpm_pkg::REG_PATTERN_1: pat_q[1] <= cfg_data;
				wwpm_pkg::REG_PATTERN_2: pat_q[2] <= cfg_data;
				wwpm_pkg::REG_PATTERN_3: pat_q[3] <= cfg_data;
				wwpm_pkg::REG_PATTERN_LEN: len_q <= cfg_data[wwpm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			fill_q <= '0;
			line_q <= wwpm_pkg::LINE_W'(1);
			col_q <= '0;
		end else if (adv) begin
			if (item_eoi) begin
				win_q <= '0;
				fill_q <= '0;
				line_q <= wwpm_pkg::LINE_W'(1);
				col_q <= '0;
			end else if (item_byte == wwpm_pkg::CHAR_NEWLINE) begin
				win_q <= '0;
				fill_q <= '0;
				if (line_q != wwpm_pkg::LINE_MAX) begin
					line_q <= line_q + wwpm_pkg::LINE_W'(1);
				end
				col_q <= '0;
			end else begin
				for (int j = DEPTH - 1; j > 0; j--) begin
					win_q[j] <= win_q[j-1];
				end
				win_q[0] <= item_byte;
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				if (col_q != wwpm_pkg::COL_MAX) begin
					col_q <= col_q + wwpm_pkg::COL_W'(1);
				end
			end
		end
	end

endmodule

@@ rtl/wwpm_outq.sv @@
module wwpm_outq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input wwpm_pkg::scan_out_t res,
	output logic [1:0] room,
	output logic out_valid,
	input logic out_ready,
	output wwpm_pkg::result_t head
);

	wwpm_pkg::result_t [1:0] ent_q;
	wwpm_pkg::result_t [1:0] ent_n;
	logic [1:0] cnt_q;
	logic [1:0] cnt_n;
	logic pop;

	assign out_valid = (cnt_q != 2'd0);
	assign head = ent_q[0];
	assign pop = out_valid && out_ready;
	assign room = 2'd2 - cnt_q + {1'b0, pop};

	always_comb begin
		ent_n = ent_q;
		cnt_n = cnt_q;
		if (pop) begin
			ent_n[0] = ent_q[1];
			cnt_n = cnt_q - 2'd1;
		end
		if (push && res.count != 2'd0) begin
			if (cnt_n == 2'd0) begin
				ent_n[0] = res.first;
				ent_n[1] = res.second;
			end else begin
				ent_n[1] = res.first;
			end
			cnt_n = cnt_n + res.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_n;
	end

endmodule
